// ===== sv/ssmd_pkg.sv =====
`timescale 1ns / 1ps
package ssmd_pkg;

  // fixed field widths of the ports
  localparam int NODE_W     = 7;
  localparam int WEIGHT_IN_W = 16;
  localparam int RESULT_W   = 22;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;

  localparam logic [NODE_W-1:0] NODE_COUNT_RST  = 7'd64;
  localparam logic [NODE_W-1:0] SOURCE_NODE_RST = 7'd1;

  localparam logic OP_EDGE  = 1'b0;
  localparam logic OP_SOLVE = 1'b1;

  typedef enum logic {
    REG_NODE_COUNT  = 1'b0,
    REG_SOURCE_NODE = 1'b1
  } reg_idx_e;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_LOAD  = 11'b000_0000_0010,
    ST_SEED  = 11'b000_0000_0100,
    ST_POP   = 11'b000_0000_1000,
    ST_FETCH = 11'b000_0001_0000,
    ST_ROW   = 11'b000_0010_0000,
    ST_RD    = 11'b000_0100_0000,
    ST_RELAX = 11'b000_1000_0000,
    ST_SRD   = 11'b001_0000_0000,
    ST_SCMP  = 11'b010_0000_0000,
    ST_CLR   = 11'b100_0000_0000
  } state_e;

  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
    logic rd;
  } q_ctl_t;

  typedef struct packed {
    logic row_rd;
    logic row_we;
    logic wt_rd;
    logic wt_we;
  } adj_ctl_t;

endpackage

// ===== sv/ssmd_adj.sv =====
`timescale 1ns / 1ps
module ssmd_adj #(
  parameter int MAX_NODES   = 64,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                             clk_i,
  input  ssmd_pkg::adj_ctl_t               ctl_i,
  input  logic [$clog2(MAX_NODES)-1:0]     row_addr_i,
  input  logic [MAX_NODES-1:0]             row_wdata_i,
  output logic [MAX_NODES-1:0]             row_rdata_o,
  input  logic [2*$clog2(MAX_NODES)-1:0]   wt_addr_i,
  input  logic [WEIGHT_BITS-1:0]           wt_wdata_i,
  output logic [WEIGHT_BITS-1:0]           wt_rdata_o
);
  import ssmd_pkg::*;

  localparam int NW       = $clog2(MAX_NODES);
  localparam int WT_DEPTH = 1 << (2 * NW);

  // one presence bit per edge, a row per source node
  logic [MAX_NODES-1:0]   row_mem [MAX_NODES];
  logic [WEIGHT_BITS-1:0] wt_mem  [WT_DEPTH];
  logic [MAX_NODES-1:0]   row_rd_q;
  logic [WEIGHT_BITS-1:0] wt_rd_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.row_we) begin
      row_mem[row_addr_i] <= row_wdata_i;
    end
    if (ctl_i.row_rd) begin
      row_rd_q <= row_mem[row_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wt_we) begin
      wt_mem[wt_addr_i] <= wt_wdata_i;
    end
    if (ctl_i.wt_rd) begin
      wt_rd_q <= wt_mem[wt_addr_i];
    end
  end

  assign row_rdata_o = row_rd_q;
  assign wt_rdata_o  = wt_rd_q;

endmodule

// ===== sv/ssmd_queue.sv =====
`timescale 1ns / 1ps
module ssmd_queue #(
  parameter int MAX_NODES = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ssmd_pkg::q_ctl_t             ctl_i,
  input  logic [$clog2(MAX_NODES)-1:0] push_node_i,
  output logic [$clog2(MAX_NODES)-1:0] head_node_o,
  output logic                         empty_o
);
  import ssmd_pkg::*;

  localparam int NW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);

  logic [NW-1:0]        q_mem [MAX_NODES];
  logic [NW-1:0]        head_q, head_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [MAX_NODES-1:0] flag_q, flag_d;
  logic [NW-1:0]        head_node_q;
  logic [CW:0]          tail_sum;
  logic [NW-1:0]        tail;
  logic                 push_ok;

  always_comb begin
    tail_sum = (CW+1)'(head_q) + (CW+1)'(cnt_q);
    if (tail_sum >= (CW+1)'(MAX_NODES)) begin
      tail = NW'(tail_sum - (CW+1)'(MAX_NODES));
    end else begin
      tail = NW'(tail_sum);
    end
  end

  // a node already waiting is not queued again
  assign push_ok = ctl_i.push && !flag_q[push_node_i] && (cnt_q < CW'(MAX_NODES));

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      q_mem[tail] <= push_node_i;
    end
    if (ctl_i.rd) begin
      head_node_q <= q_mem[head_q];
    end
  end

  always_comb begin
    head_d = head_q;
    cnt_d  = cnt_q;
    flag_d = flag_q;
    if (ctl_i.clear) begin
      head_d = '0;
      cnt_d  = '0;
      flag_d = '0;
    end else if (push_ok) begin
      cnt_d               = cnt_q + CW'(1);
      flag_d[push_node_i] = 1'b1;
    end else if (ctl_i.pop) begin
      head_d              = (head_q == NW'(MAX_NODES - 1)) ? '0 : head_q + NW'(1);
      cnt_d               = cnt_q - CW'(1);
      flag_d[head_node_q] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      cnt_q  <= '0;
      flag_q <= '0;
    end else begin
      head_q <= head_d;
      cnt_q  <= cnt_d;
      flag_q <= flag_d;
    end
  end

  assign head_node_o = head_node_q;
  assign empty_o     = (cnt_q == '0);

endmodule

// ===== sv/ssmd_ctrl.sv =====
`timescale 1ns / 1ps
module ssmd_ctrl #(
  parameter int MAX_NODES   = 64,
  parameter int WEIGHT_BITS = 16,
  parameter int DIST_BITS   = 22
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic                                   op_i,
  input  logic [ssmd_pkg::NODE_W-1:0]            from_node_i,
  input  logic [ssmd_pkg::NODE_W-1:0]            to_node_i,
  input  logic [ssmd_pkg::WEIGHT_IN_W-1:0]       edge_weight_i,
  input  logic [ssmd_pkg::NODE_W-1:0]            node_count_i,
  input  logic [ssmd_pkg::NODE_W-1:0]            source_node_i,
  output logic                                   busy_o,
  output logic                                   done_o,
  output logic [ssmd_pkg::RESULT_W-1:0]          max_delay_o,
  output logic                                   unreachable_o,
  output ssmd_pkg::adj_ctl_t                     adj_ctl_o,
  output logic [$clog2(MAX_NODES)-1:0]           adj_row_addr_o,
  output logic [MAX_NODES-1:0]                   adj_row_wdata_o,
  input  logic [MAX_NODES-1:0]                   adj_row_rdata_i,
  output logic [2*$clog2(MAX_NODES)-1:0]         adj_wt_addr_o,
  output logic [WEIGHT_BITS-1:0]                 adj_wt_wdata_o,
  input  logic [WEIGHT_BITS-1:0]                 adj_wt_rdata_i,
  output ssmd_pkg::q_ctl_t                       q_ctl_o,
  output logic [$clog2(MAX_NODES)-1:0]           q_push_node_o,
  input  logic [$clog2(MAX_NODES)-1:0]           q_head_node_i,
  input  logic                                   q_empty_i
);
  import ssmd_pkg::*;

  localparam int NW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int SW = ((DIST_BITS > WEIGHT_BITS) ? DIST_BITS : WEIGHT_BITS) + 1;
  localparam logic [DIST_BITS-1:0] DIST_INF = '1;
  localparam logic [DIST_BITS-1:0] DIST_TOP = {{(DIST_BITS-1){1'b1}}, 1'b0};
  localparam logic [MAX_NODES-1:0] ROW_ONE  = {{(MAX_NODES-1){1'b0}}, 1'b1};

  state_e               state_q, state_d;
  logic [NW-1:0]        a_q, a_d, b_q, b_d, u_q, u_d;
  logic [WEIGHT_BITS-1:0] w_q, w_d;
  logic [DIST_BITS-1:0] du_q, du_d, best_q, best_d;
  logic                 unreach_q, unreach_d;
  logic [CW-1:0]        i_q, i_d;
  logic                 done_q, done_d;
  logic [RESULT_W-1:0]  max_q, max_d;
  logic                 unr_q, unr_d;

  // distance store: memory plus one valid bit per node (invalid reads as infinity)
  logic [DIST_BITS-1:0] dist_mem [MAX_NODES];
  logic [MAX_NODES-1:0] dist_vld_q;
  logic [DIST_BITS-1:0] dist_rd_q;
  logic                 dist_rd_vld_q;
  logic                 dist_clr, dist_we;
  logic [NW-1:0]        dist_raddr, dist_waddr;
  logic [DIST_BITS-1:0] dist_wdata, dist_val;

  logic [CW-1:0]        n_act;
  logic                 from_ok, to_ok, src_ok;
  logic [NW-1:0]        from_idx, to_idx, src_idx, i_idx;
  logic [SW-1:0]        sum;
  logic [DIST_BITS-1:0] cand;

  always_comb begin
    if (32'(node_count_i) > 32'(MAX_NODES)) begin
      n_act = CW'(MAX_NODES);
    end else begin
      n_act = CW'(node_count_i);
    end
  end

  assign from_ok  = (from_node_i != '0) && (32'(from_node_i) <= 32'(n_act));
  assign to_ok    = (to_node_i != '0) && (32'(to_node_i) <= 32'(n_act));
  assign src_ok   = (source_node_i != '0) && (32'(source_node_i) <= 32'(n_act));
  assign from_idx = NW'(from_node_i - NODE_W'(1));
  assign to_idx   = NW'(to_node_i - NODE_W'(1));
  assign src_idx  = NW'(source_node_i - NODE_W'(1));
  assign i_idx    = i_q[NW-1:0];

  assign dist_val = dist_rd_vld_q ? dist_rd_q : DIST_INF;

  // shared relax unit: saturating add, compare in the FSM
  assign sum  = SW'(du_q) + SW'(adj_wt_rdata_i);
  assign cand = (sum > SW'(DIST_TOP)) ? DIST_TOP : DIST_BITS'(sum);

  always_comb begin
    state_d   = state_q;
    a_d       = a_q;
    b_d       = b_q;
    w_d       = w_q;
    u_d       = u_q;
    du_d      = du_q;
    best_d    = best_q;
    unreach_d = unreach_q;
    i_d       = i_q;
    done_d    = 1'b0;
    max_d     = max_q;
    unr_d     = unr_q;

    adj_ctl_o       = '0;
    adj_row_addr_o  = a_q;
    adj_row_wdata_o = adj_row_rdata_i | (ROW_ONE << b_q);
    adj_wt_addr_o   = {a_q, b_q};
    adj_wt_wdata_o  = w_q;

    q_ctl_o       = '0;
    q_push_node_o = i_idx;

    dist_clr   = 1'b0;
    dist_we    = 1'b0;
    dist_raddr = i_idx;
    dist_waddr = i_idx;
    dist_wdata = cand;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (op_i == OP_SOLVE) begin
            dist_clr      = 1'b1;
            q_ctl_o.clear = 1'b1;
            state_d       = ST_SEED;
          end else if (from_ok && to_ok) begin
            // read the row now, merge the new bit next cycle
            adj_ctl_o.row_rd = 1'b1;
            adj_row_addr_o   = from_idx;
            a_d              = from_idx;
            b_d              = to_idx;
            w_d              = WEIGHT_BITS'(edge_weight_i);
            state_d          = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        adj_ctl_o.row_we = 1'b1;
        adj_ctl_o.wt_we  = 1'b1;
        state_d          = ST_IDLE;
      end
      ST_SEED: begin
        if (src_ok) begin
          dist_we       = 1'b1;
          dist_waddr    = src_idx;
          dist_wdata    = '0;
          q_ctl_o.push  = 1'b1;
          q_push_node_o = src_idx;
        end
        state_d = ST_POP;
      end
      ST_POP: begin
        if (q_empty_i) begin
          i_d       = '0;
          best_d    = '0;
          unreach_d = 1'b0;
          state_d   = ST_SRD;
        end else begin
          q_ctl_o.rd = 1'b1;
          state_d    = ST_FETCH;
        end
      end
      ST_FETCH: begin
        q_ctl_o.pop      = 1'b1;
        u_d              = q_head_node_i;
        adj_ctl_o.row_rd = 1'b1;
        adj_row_addr_o   = q_head_node_i;
        dist_raddr       = q_head_node_i;
        state_d          = ST_ROW;
      end
      ST_ROW: begin
        du_d    = dist_val;
        i_d     = '0;
        state_d = ST_RD;
      end
      ST_RD: begin
        if (i_q == n_act) begin
          state_d = ST_POP;
        end else if (!adj_row_rdata_i[i_idx]) begin
          i_d = i_q + CW'(1);
        end else begin
          adj_ctl_o.wt_rd = 1'b1;
          adj_wt_addr_o   = {u_q, i_idx};
          state_d         = ST_RELAX;
        end
      end
      ST_RELAX: begin
        if (cand < dist_val) begin
          dist_we      = 1'b1;
          q_ctl_o.push = 1'b1;
        end
        i_d     = i_q + CW'(1);
        state_d = ST_RD;
      end
      ST_SRD: begin
        if (i_q == n_act) begin
          done_d  = 1'b1;
          max_d   = unreach_q ? '0 : RESULT_W'(best_q);
          unr_d   = unreach_q;
          i_d     = '0;
          state_d = ST_CLR;
        end else begin
          state_d = ST_SCMP;
        end
      end
      ST_SCMP: begin
        if (dist_val == DIST_INF) begin
          unreach_d = 1'b1;
        end else if (dist_val > best_q) begin
          best_d = dist_val;
        end
        i_d     = i_q + CW'(1);
        state_d = ST_SRD;
      end
      ST_CLR: begin
        adj_ctl_o.row_we = 1'b1;
        adj_row_addr_o   = i_idx;
        adj_row_wdata_o  = '0;
        if (i_q == CW'(MAX_NODES - 1)) begin
          state_d = ST_IDLE;
        end else begin
          i_d = i_q + CW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (dist_we) begin
      dist_mem[dist_waddr] <= dist_wdata;
    end
    dist_rd_q <= dist_mem[dist_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_vld_q    <= '0;
      dist_rd_vld_q <= 1'b0;
    end else begin
      if (dist_clr) begin
        dist_vld_q <= '0;
      end else if (dist_we) begin
        dist_vld_q[dist_waddr] <= 1'b1;
      end
      dist_rd_vld_q <= dist_vld_q[dist_raddr];
    end
  end

  // after reset the adjacency rows are swept clear first
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      i_q     <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q       <= a_d;
    b_q       <= b_d;
    w_q       <= w_d;
    u_q       <= u_d;
    du_q      <= du_d;
    best_q    <= best_d;
    unreach_q <= unreach_d;
    max_q     <= max_d;
    unr_q     <= unr_d;
  end

  assign busy_o        = (state_q != ST_IDLE);
  assign done_o        = done_q;
  assign max_delay_o   = max_q;
  assign unreachable_o = unr_q;

endmodule

// ===== sv/single_source_max_delay.sv =====
`timescale 1ns / 1ps
// Network delay solver. An item with op_i low stores one directed edge: the
// row is read, then row and weight are written in ST_LOAD with busy_o high
// (an edge with a node outside 1..node_count is dropped, busy_o stays low).
// An item with op_i high runs SPFA relaxation from source_node: setup in
// ST_SEED, then per node taken from the queue ST_POP, ST_FETCH and ST_ROW
// plus, for each node index below node_count, ST_RD when no edge is stored
// and ST_RD and ST_RELAX when one is (one pass of the shared add/compare
// unit), then a scan for the maximum through ST_SRD and ST_SCMP. The result
// shows on done_o for exactly one cycle and must be taken then; the receiver
// cannot stall it. A sweep then clears the adjacency rows, as after reset;
// busy_o stays high throughout and start_i is ignored while busy_o is high.
module single_source_max_delay #(
  parameter int MAX_NODES   = 64,
  parameter int WEIGHT_BITS = 16,
  parameter int DIST_BITS   = 22
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic                               op_i,
  input  logic [ssmd_pkg::NODE_W-1:0]        from_node_i,
  input  logic [ssmd_pkg::NODE_W-1:0]        to_node_i,
  input  logic [ssmd_pkg::WEIGHT_IN_W-1:0]   edge_weight_i,
  output logic                               done_o,
  output logic [ssmd_pkg::RESULT_W-1:0]      max_delay_o,
  output logic                               unreachable_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ssmd_pkg::APB_AW-1:0]        paddr,
  input  logic [ssmd_pkg::APB_DW-1:0]        pwdata,
  output logic [ssmd_pkg::APB_DW-1:0]        prdata,
  output logic                               pready
);
  import ssmd_pkg::*;

  localparam int NW = $clog2(MAX_NODES);

  logic [NODE_W-1:0] node_count_q, source_node_q;
  reg_idx_e          reg_idx;
  logic              reg_wr;

  adj_ctl_t               adj_ctl;
  logic [NW-1:0]          adj_row_addr;
  logic [MAX_NODES-1:0]   adj_row_wdata, adj_row_rdata;
  logic [2*NW-1:0]        adj_wt_addr;
  logic [WEIGHT_BITS-1:0] adj_wt_wdata, adj_wt_rdata;
  q_ctl_t                 q_ctl;
  logic [NW-1:0]          q_push_node, q_head_node;
  logic                   q_empty;

  assign reg_idx = reg_idx_e'(paddr[2]);
  assign reg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q  <= NODE_COUNT_RST;
      source_node_q <= SOURCE_NODE_RST;
    end else if (reg_wr) begin
      case (reg_idx)
        REG_NODE_COUNT:  node_count_q  <= pwdata[NODE_W-1:0];
        REG_SOURCE_NODE: source_node_q <= pwdata[NODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_NODE_COUNT:  prdata = APB_DW'(node_count_q);
      REG_SOURCE_NODE: prdata = APB_DW'(source_node_q);
      default:         prdata = '0;
    endcase
  end

  ssmd_ctrl #(
    .MAX_NODES  (MAX_NODES),
    .WEIGHT_BITS(WEIGHT_BITS),
    .DIST_BITS  (DIST_BITS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .op_i           (op_i),
    .from_node_i    (from_node_i),
    .to_node_i      (to_node_i),
    .edge_weight_i  (edge_weight_i),
    .node_count_i   (node_count_q),
    .source_node_i  (source_node_q),
    .busy_o         (busy_o),
    .done_o         (done_o),
    .max_delay_o    (max_delay_o),
    .unreachable_o  (unreachable_o),
    .adj_ctl_o      (adj_ctl),
    .adj_row_addr_o (adj_row_addr),
    .adj_row_wdata_o(adj_row_wdata),
    .adj_row_rdata_i(adj_row_rdata),
    .adj_wt_addr_o  (adj_wt_addr),
    .adj_wt_wdata_o (adj_wt_wdata),
    .adj_wt_rdata_i (adj_wt_rdata),
    .q_ctl_o        (q_ctl),
    .q_push_node_o  (q_push_node),
    .q_head_node_i  (q_head_node),
    .q_empty_i      (q_empty)
  );

  ssmd_adj #(
    .MAX_NODES  (MAX_NODES),
    .WEIGHT_BITS(WEIGHT_BITS)
  ) u_adj (
    .clk_i      (clk_i),
    .ctl_i      (adj_ctl),
    .row_addr_i (adj_row_addr),
    .row_wdata_i(adj_row_wdata),
    .row_rdata_o(adj_row_rdata),
    .wt_addr_i  (adj_wt_addr),
    .wt_wdata_i (adj_wt_wdata),
    .wt_rdata_o (adj_wt_rdata)
  );

  ssmd_queue #(
    .MAX_NODES(MAX_NODES)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (q_ctl),
    .push_node_i(q_push_node),
    .head_node_o(q_head_node),
    .empty_o    (q_empty)
  );

endmodule

// ===== sv/ssmd_checker.sv =====
`timescale 1ns / 1ps
module ssmd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start_i,
  input logic                          busy_o,
  input logic                          op_i,
  input logic                          done_o,
  input logic [ssmd_pkg::RESULT_W-1:0] max_delay_o,
  input logic                          unreachable_o
);
  import ssmd_pkg::*;

  // a solve always keeps the block busy past its start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (op_i == OP_SOLVE) |=> busy_o)
    else $error("solve item accepted but block not busy");

  // the result comes out while the clear sweep is already running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o)
    else $error("result strobe while idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && unreachable_o |-> (max_delay_o == '0))
    else $error("unreachable result with nonzero delay");

endmodule

bind single_source_max_delay ssmd_checker u_ssmd_checker (.*);

// ===== tb/sv/single_source_max_delay_test.sv =====
`timescale 1ns / 1ps
module single_source_max_delay_test;
  import ssmd_pkg::*;

  localparam int MAX_NODES   = 64;
  localparam int DIST_BITS   = 22;
  localparam logic [DIST_BITS-1:0] DIST_INF = '1;
  localparam int STALL_LIMIT = 2000000;
  localparam int ITEM_TARGET = 1700;

  typedef struct packed {
    logic                   op;
    logic [NODE_W-1:0]      src_node;
    logic [NODE_W-1:0]      dst_node;
    logic [WEIGHT_IN_W-1:0] weight;
  } net_item_t;

  typedef struct packed {
    logic [RESULT_W-1:0] max_delay;
    logic                unreachable;
  } delay_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   start_i = 1'b0;
  logic                   busy_o;
  logic                   op_i = OP_EDGE;
  logic [NODE_W-1:0]      from_node_i = '0;
  logic [NODE_W-1:0]      to_node_i = '0;
  logic [WEIGHT_IN_W-1:0] edge_weight_i = '0;
  logic                   done_o;
  logic [RESULT_W-1:0]    max_delay_o;
  logic                   unreachable_o;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [APB_AW-1:0]      paddr = '0;
  logic [APB_DW-1:0]      pwdata = '0;
  logic [APB_DW-1:0]      prdata;
  logic                   pready;

  // network copy kept alongside the block
  logic [WEIGHT_IN_W-1:0] edge_wt [MAX_NODES][MAX_NODES];
  bit                     edge_set [MAX_NODES][MAX_NODES];
  logic [NODE_W-1:0]      cur_node_count = NODE_COUNT_RST;
  logic [NODE_W-1:0]      cur_source = SOURCE_NODE_RST;
  delay_result_t          pending_delays [$];
  int unsigned            mismatches = 0;
  int unsigned            graph_items = 0;
  int unsigned            stall_cycles = 0;
  bit                     steady = 1'b0;

  single_source_max_delay u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .op_i          (op_i),
    .from_node_i   (from_node_i),
    .to_node_i     (to_node_i),
    .edge_weight_i (edge_weight_i),
    .done_o        (done_o),
    .max_delay_o   (max_delay_o),
    .unreachable_o (unreachable_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at %0t: %s", $time, msg);
  endfunction

  function automatic int unsigned live_nodes();
    return (cur_node_count > MAX_NODES) ? MAX_NODES : cur_node_count;
  endfunction

  // SPFA from the current source; clears the edge store afterwards
  function automatic delay_result_t solve_network();
    int unsigned          n;
    int unsigned          head;
    int unsigned          count;
    int unsigned          u;
    logic [DIST_BITS-1:0] dist_v [MAX_NODES];
    bit                   waiting [MAX_NODES];
    int unsigned          fifo [MAX_NODES];
    logic [DIST_BITS:0]   cand;
    delay_result_t        res;
    n = live_nodes();
    head = 0;
    count = 0;
    for (int i = 0; i < MAX_NODES; i++) begin
      dist_v[i] = DIST_INF;
      waiting[i] = 1'b0;
    end
    if (cur_source >= 1 && cur_source <= n) begin
      dist_v[cur_source - 1] = '0;
      fifo[0] = cur_source - 1;
      waiting[cur_source - 1] = 1'b1;
      count = 1;
    end
    while (count > 0) begin
      u = fifo[head];
      head = (head + 1) % MAX_NODES;
      count--;
      waiting[u] = 1'b0;
      for (int i = 0; i < n; i++) begin
        if (edge_set[u][i]) begin
          cand = {1'b0, dist_v[u]} + (DIST_BITS+1)'(edge_wt[u][i]);
          if (cand > {1'b0, DIST_INF - DIST_BITS'(1)}) cand = {1'b0, DIST_INF - DIST_BITS'(1)};
          if (cand < {1'b0, dist_v[i]}) begin
            dist_v[i] = cand[DIST_BITS-1:0];
            if (!waiting[i]) begin
              fifo[(head + count) % MAX_NODES] = i;
              count++;
              waiting[i] = 1'b1;
            end
          end
        end
      end
    end
    res = '0;
    for (int i = 0; i < n; i++) begin
      if (dist_v[i] == DIST_INF) res.unreachable = 1'b1;
      else if (dist_v[i] > res.max_delay) res.max_delay = dist_v[i];
    end
    if (res.unreachable) res.max_delay = '0;
    for (int a = 0; a < MAX_NODES; a++) begin
      for (int b = 0; b < MAX_NODES; b++) edge_set[a][b] = 1'b0;
    end
    return res;
  endfunction

  function automatic void update_network(input net_item_t it);
    int unsigned n;
    n = live_nodes();
    if (it.op == OP_EDGE) begin
      if (it.src_node >= 1 && it.src_node <= n && it.dst_node >= 1 && it.dst_node <= n) begin
        edge_wt[it.src_node - 1][it.dst_node - 1] = it.weight;
        edge_set[it.src_node - 1][it.dst_node - 1] = 1'b1;
      end
    end else begin
      pending_delays.push_back(solve_network());
    end
    graph_items++;
  endfunction

  function automatic net_item_t link_item(input int unsigned a, input int unsigned b,
                                          input int unsigned w);
    net_item_t it;
    it.op = OP_EDGE;
    it.src_node = NODE_W'(a);
    it.dst_node = NODE_W'(b);
    it.weight = WEIGHT_IN_W'(w);
    return it;
  endfunction

  // node fields are don't-care on a solve, so fill them with noise
  function automatic net_item_t solve_item();
    net_item_t it;
    it.op = OP_SOLVE;
    it.src_node = NODE_W'($urandom);
    it.dst_node = NODE_W'($urandom);
    it.weight = WEIGHT_IN_W'($urandom);
    return it;
  endfunction

  function automatic int unsigned pick_weight(input bit heavy);
    if (heavy) return 16'hFFFF;
    if ($urandom_range(0, 99) < 40) return $urandom_range(0, 15);
    return $urandom_range(0, 65535);
  endfunction

  function automatic net_item_t random_link(input int unsigned nl);
    if (nl != 0 && $urandom_range(0, 99) < 85)
      return link_item($urandom_range(1, nl), $urandom_range(1, nl), pick_weight(1'b0));
    return link_item($urandom_range(0, 127), $urandom_range(0, 127), pick_weight(1'b0));
  endfunction

  task automatic send_item(input net_item_t it);
    if (!steady && $urandom_range(0, 99) < 16) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    start_i       <= 1'b1;
    op_i          <= it.op;
    from_node_i   <= it.src_node;
    to_node_i     <= it.dst_node;
    edge_weight_i <= it.weight;
    do @(negedge clk_i); while (busy_o);
    @(posedge clk_i);
    update_network(it);
  endtask

  // drain results, then let any trailing edge load or clear sweep finish
  task automatic wait_idle();
    start_i <= 1'b0;
    while (pending_delays.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    do @(negedge clk_i); while (busy_o);
    @(posedge clk_i);
  endtask

  task automatic cfg_write(input reg_idx_e idx, input logic [NODE_W-1:0] value);
    logic [APB_DW-1:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= APB_DW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (!pready);
    @(posedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (!pready);
    rd = prdata;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_NODE_COUNT) cur_node_count = value;
    else cur_source = value;
    if (rd[NODE_W-1:0] !== value)
      note_mismatch($sformatf("reg %s read back expected %0d got %0d",
                              idx.name(), value, rd[NODE_W-1:0]));
  endtask

  task automatic test_reset_state();
    wait_idle();
    send_item(solve_item());
  endtask

  task automatic test_single_node();
    wait_idle();
    cfg_write(REG_NODE_COUNT, 1);
    send_item(link_item(1, 1, 16'hFFFF));
    send_item(solve_item());
  endtask

  task automatic test_zero_nodes();
    wait_idle();
    cfg_write(REG_NODE_COUNT, 0);
    send_item(link_item(1, 1, 5));
    send_item(solve_item());
  endtask

  // a count above the store size acts as the full size
  task automatic test_oversized_count();
    wait_idle();
    cfg_write(REG_NODE_COUNT, 127);
    cfg_write(REG_SOURCE_NODE, 64);
    send_item(link_item(64, 1, 7));
    send_item(link_item(127, 1, 3));
    send_item(solve_item());
  endtask

  task automatic test_source_out_of_range();
    wait_idle();
    cfg_write(REG_NODE_COUNT, 3);
    cfg_write(REG_SOURCE_NODE, 5);
    send_item(link_item(1, 2, 1));
    send_item(solve_item());
    wait_idle();
    cfg_write(REG_SOURCE_NODE, 0);
    send_item(solve_item());
    wait_idle();
    cfg_write(REG_SOURCE_NODE, 127);
    send_item(solve_item());
  endtask

  task automatic test_edge_overwrite();
    wait_idle();
    cfg_write(REG_NODE_COUNT, 3);
    cfg_write(REG_SOURCE_NODE, 1);
    send_item(link_item(1, 2, 10));
    send_item(link_item(1, 2, 3));
    send_item(link_item(2, 3, 16'hFFFF));
    send_item(link_item(1, 3, 0));
    send_item(link_item(0, 2, 0));
    send_item(link_item(1, 4, 0));
    send_item(solve_item());
  endtask

  // the shortcut through node 4 must not be used once the count drops
  task automatic test_shrunken_count();
    wait_idle();
    cfg_write(REG_NODE_COUNT, 4);
    cfg_write(REG_SOURCE_NODE, 1);
    send_item(link_item(1, 4, 1));
    send_item(link_item(4, 2, 1));
    send_item(link_item(1, 2, 100));
    send_item(link_item(1, 3, 5));
    wait_idle();
    cfg_write(REG_NODE_COUNT, 3);
    send_item(solve_item());
  endtask

  task automatic test_random_graphs();
    int unsigned n;
    int unsigned nl;
    int unsigned src;
    int unsigned pick;
    int unsigned j;
    int unsigned tmp;
    int unsigned graph_no;
    bit          chain;
    bit          heavy;
    int unsigned perm [MAX_NODES];
    graph_no = 0;
    while (graph_items < ITEM_TARGET) begin
      steady = (graph_no >= 20 && graph_no < 45);
      pick = $urandom_range(0, 99);
      if (pick < 60) n = $urandom_range(2, 10);
      else if (pick < 80) n = $urandom_range(11, 32);
      else if (pick < 88) n = 64;
      else if (pick < 93) n = $urandom_range(65, 127);
      else if (pick < 97) n = 1;
      else n = 0;
      nl = (n > MAX_NODES) ? MAX_NODES : n;
      if (nl != 0 && $urandom_range(0, 9) != 0) src = $urandom_range(1, nl);
      else src = $urandom_range(0, 127);
      wait_idle();
      cfg_write(REG_NODE_COUNT, n);
      cfg_write(REG_SOURCE_NODE, src);

      pick = $urandom_range(0, 9);
      if (pick < 7 && nl > 1) begin
        // spanning tree rooted at the source when it is a live node, plus extra links, or a bare chain
        for (int i = 0; i < nl; i++) perm[i] = i + 1;
        for (int i = nl - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          tmp = perm[i];
          perm[i] = perm[j];
          perm[j] = tmp;
        end
        for (int i = 0; i < nl; i++) begin
          if (perm[i] == src) begin
            perm[i] = perm[0];
            perm[0] = src;
          end
        end
        chain = (pick < 2);
        heavy = chain && $urandom_range(0, 1);
        for (int i = 1; i < nl; i++) begin
          j = chain ? i - 1 : $urandom_range(0, i - 1);
          send_item(link_item(perm[j], perm[i], pick_weight(heavy)));
        end
        if (!chain) begin
          repeat ($urandom_range(0, nl)) send_item(random_link(nl));
        end
      end else begin
        repeat ($urandom_range(0, 2 * nl + 4)) send_item(random_link(nl));
      end

      if ($urandom_range(0, 9) == 0) begin
        wait_idle();
        cfg_write(REG_NODE_COUNT, $urandom_range(0, nl));
      end
      send_item(solve_item());
      if ($urandom_range(0, 9) == 0) send_item(solve_item());
      graph_no++;
    end
    steady = 1'b0;
  endtask

  always @(negedge clk_i) begin : check_result
    delay_result_t want;
    if (rst_ni && done_o) begin
      if (pending_delays.size() == 0) begin
        note_mismatch("result with no solve outstanding");
      end else begin
        want = pending_delays.pop_front();
        if (max_delay_o !== want.max_delay)
          note_mismatch($sformatf("max_delay expected %0d got %0d",
                                  want.max_delay, max_delay_o));
        if (unreachable_o !== want.unreachable)
          note_mismatch($sformatf("unreachable expected %0b got %0b",
                                  want.unreachable, unreachable_o));
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_single_node();
    test_zero_nodes();
    test_oversized_count();
    test_source_out_of_range();
    test_edge_overwrite();
    test_shrunken_count();
    test_random_graphs();
    wait_idle();
    repeat (4 * MAX_NODES) @(posedge clk_i);
    if (mismatches == 0 && pending_delays.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
